// ===== rtl/tss_pkg.sv =====
package tss_pkg;

  // default sizes
  localparam int STACK_DEPTH_DEF = 256;
  localparam int TAG_WIDTH_DEF   = 8;
  localparam int UNKNOWN_TAG_DEF = 0;

  // stream payload widths
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 48;
  localparam int OP_W       = 3;
  localparam int FIELD_W    = 8;
  localparam int STATUS_W   = 2;
  localparam int DEPTH_W    = 9;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 3'd0,
    OP_PUSH  = 3'd1,
    OP_POP   = 3'd2,
    OP_READ  = 3'd3,
    OP_FIND  = 3'd4
  } op_t;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISS     = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_TOP_WAIT,
    S_RD_WAIT,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic top_load;
    logic rd_load;
    logic scan_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic empty;
    logic ge2;
    logic idx_ok;
    logic hit;
    logic ptr_zero;
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/tss_ctrl.sv =====
module tss_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  tss_pkg::stat_t  stat,
  output tss_pkg::cmd_t   cmd
);

  tss_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tss_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      tss_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = tss_pkg::S_EXEC;
        end
      end
      tss_pkg::S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = tss_pkg::S_DONE;
        case (stat.op)
          tss_pkg::OP_POP: begin
            if (!stat.empty && stat.ge2) state_next = tss_pkg::S_TOP_WAIT;
          end
          tss_pkg::OP_READ: begin
            if (stat.idx_ok) state_next = tss_pkg::S_RD_WAIT;
          end
          tss_pkg::OP_FIND: begin
            if (!stat.empty) state_next = tss_pkg::S_SCAN;
          end
          default: begin
            state_next = tss_pkg::S_DONE;
          end
        endcase
      end
      tss_pkg::S_TOP_WAIT: begin
        cmd.top_load = 1'b1;
        state_next   = tss_pkg::S_DONE;
      end
      tss_pkg::S_RD_WAIT: begin
        cmd.rd_load = 1'b1;
        state_next  = tss_pkg::S_DONE;
      end
      tss_pkg::S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.hit || stat.ptr_zero) state_next = tss_pkg::S_DONE;
      end
      tss_pkg::S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          s_tready     = 1'b1;
          if (s_tvalid) begin
            cmd.load_in = 1'b1;
            state_next  = tss_pkg::S_EXEC;
          end else begin
            state_next = tss_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_next = tss_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/tss_dp.sv =====
module tss_dp #(
  parameter int STACK_DEPTH = tss_pkg::STACK_DEPTH_DEF,
  parameter int TAG_WIDTH   = tss_pkg::TAG_WIDTH_DEF,
  parameter int UNKNOWN_TAG = tss_pkg::UNKNOWN_TAG_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [tss_pkg::IN_DATA_W-1:0]  s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [tss_pkg::OUT_DATA_W-1:0] m_tdata,
  input  tss_pkg::cmd_t                  cmd,
  output tss_pkg::stat_t                 stat
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int IW = (CW > tss_pkg::FIELD_W) ? CW : tss_pkg::FIELD_W;
  localparam logic [TAG_WIDTH-1:0] UNK = TAG_WIDTH'(UNKNOWN_TAG);

  logic [TAG_WIDTH-1:0] mem [STACK_DEPTH];
  logic [TAG_WIDTH-1:0] rdata;
  logic [AW-1:0]        rd_addr;

  tss_pkg::op_t                 op_reg;
  logic [TAG_WIDTH-1:0]         tag_reg;
  logic [tss_pkg::FIELD_W-1:0]  idx_reg;

  logic [CW-1:0]                count;
  logic [TAG_WIDTH-1:0]         bottom;
  logic [TAG_WIDTH-1:0]         top;
  logic [AW-1:0]                ptr;

  logic [TAG_WIDTH-1:0]         res_tag;
  logic [AW-1:0]                res_idx;
  logic [tss_pkg::STATUS_W-1:0] res_st;

  logic full;
  logic push_ok;

  assign full    = (count == CW'(STACK_DEPTH));
  assign push_ok = cmd.exec && (op_reg == tss_pkg::OP_PUSH) && !full;

  assign stat.op       = op_reg;
  assign stat.empty    = (count == '0);
  assign stat.ge2      = (count >= CW'(2));
  assign stat.idx_ok   = (IW'(idx_reg) < IW'(count));
  assign stat.hit      = (rdata == tag_reg);
  assign stat.ptr_zero = (ptr == '0);
  assign stat.out_free = !m_tvalid || m_tready;

  // read address mux
  always_comb begin
    rd_addr = AW'(ptr - AW'(1));
    if (cmd.exec) begin
      case (op_reg)
        tss_pkg::OP_POP:  rd_addr = AW'(count - CW'(2));
        tss_pkg::OP_READ: rd_addr = AW'(idx_reg);
        default:          rd_addr = AW'(count - CW'(1));
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[rd_addr];
    if (push_ok) mem[AW'(count)] <= tag_reg;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_reg  <= tss_pkg::op_t'(s_tdata[2:0]);
      tag_reg <= TAG_WIDTH'(s_tdata[10:3]);
      idx_reg <= s_tdata[18:11];
    end

    if (cmd.exec) begin
      res_idx <= '0;
      case (op_reg)
        tss_pkg::OP_PUSH: begin
          res_tag <= UNK;
          res_st  <= full ? tss_pkg::ST_OVERFLOW : tss_pkg::ST_OK;
          if (!full) begin
            top <= tag_reg;
            if (count == '0) bottom <= tag_reg;
          end
        end
        tss_pkg::OP_POP: begin
          res_tag <= (count == '0) ? UNK : top;
          res_st  <= (count == '0) ? tss_pkg::ST_MISS : tss_pkg::ST_OK;
        end
        tss_pkg::OP_READ: begin
          res_tag <= UNK;
          res_st  <= stat.idx_ok ? tss_pkg::ST_OK : tss_pkg::ST_MISS;
        end
        tss_pkg::OP_FIND: begin
          res_tag <= UNK;
          res_st  <= tss_pkg::ST_MISS;
          ptr     <= AW'(count - CW'(1));
        end
        default: begin
          res_tag <= UNK;
          res_st  <= tss_pkg::ST_OK;
        end
      endcase
    end

    if (cmd.top_load) top <= rdata;
    if (cmd.rd_load) res_tag <= rdata;

    // one entry compared per cycle, next address already issued
    if (cmd.scan_step) begin
      if (stat.hit) begin
        res_idx <= ptr;
        res_tag <= tag_reg;
        res_st  <= tss_pkg::ST_OK;
      end else if (ptr != '0) begin
        ptr <= ptr - AW'(1);
      end
    end

    if (cmd.out_load) begin
      m_tdata[7:0]   <= tss_pkg::FIELD_W'(res_tag);
      m_tdata[15:8]  <= tss_pkg::FIELD_W'(res_idx);
      m_tdata[17:16] <= res_st;
      m_tdata[26:18] <= tss_pkg::DEPTH_W'(count);
      m_tdata[34:27] <= tss_pkg::FIELD_W'((count == '0) ? UNK : bottom);
      m_tdata[42:35] <= tss_pkg::FIELD_W'((count == '0) ? UNK : top);
      m_tdata[47:43] <= '0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.exec) begin
        case (op_reg)
          tss_pkg::OP_CLEAR: count <= '0;
          tss_pkg::OP_PUSH:  if (!full) count <= count + CW'(1);
          tss_pkg::OP_POP:   if (count != '0) count <= count - CW'(1);
          default:           count <= count;
        endcase
      end
      if (cmd.out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

endmodule

// ===== rtl/tag_stack_with_search.sv =====
// channel | dir | beat contents
// s_*     | in  | one stack operation: operation, tag_in, index_in
// m_*     | out | one result per operation: tag, index, status, depth, bottom, top
//
// clear and push go from the execute step straight to the done step
// pop adds a top-wait step when a new top tag is fetched from the entry memory
// read adds a read-wait step unless out of range; find adds one scan step per entry compared
// rst clears the fill count and the output valid; the entry memory needs no clearing
// a stalled result holds its beat; the next operation is taken meanwhile and
// waits in its last step until the output register is free
module tag_stack_with_search #(
  parameter int STACK_DEPTH = tss_pkg::STACK_DEPTH_DEF,
  parameter int TAG_WIDTH   = tss_pkg::TAG_WIDTH_DEF,
  parameter int UNKNOWN_TAG = tss_pkg::UNKNOWN_TAG_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [2:0] operation, [10:3] tag_in, [18:11] index_in, [23:19] zero
  input  logic [tss_pkg::IN_DATA_W-1:0]  s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [7:0] tag_out, [15:8] found_index, [17:16] status, [26:18] depth_now,
  // [34:27] bottom_tag, [42:35] top_tag, [47:43] zero
  output logic [tss_pkg::OUT_DATA_W-1:0] m_tdata
);

  // controller to datapath commands and the status fed back
  tss_pkg::cmd_t  cmd;
  tss_pkg::stat_t stat;

  tss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // entry memory, count, cached bottom and top tags, find pointer, output register
  tss_dp #(
    .STACK_DEPTH (STACK_DEPTH),
    .TAG_WIDTH   (TAG_WIDTH),
    .UNKNOWN_TAG (UNKNOWN_TAG)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule
